[hdl/fpam_pkg.sv]
// ----------------------------------------------------------------------------
// fpam_pkg
// Shared types and constants for the fixed-point polygon affine map.
// ----------------------------------------------------------------------------
package fpam_pkg;

	localparam int COORD_W    = 32;
	localparam int PROD_W     = 2 * COORD_W;
	localparam int PROD_SHIFT = 16;
	localparam int SUM_W      = 40;
	localparam int OUT_SHIFT  = 8;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COEF_XX  = 3'd0,
		CFG_COEF_YX  = 3'd1,
		CFG_COEF_XY  = 3'd2,
		CFG_COEF_YY  = 3'd3,
		CFG_OFFSET_X = 3'd4,
		CFG_OFFSET_Y = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic load_s2;
		logic load_s3;
	} pipe_ctl_t;

endpackage

[hdl/fpam_axis.sv]
// ----------------------------------------------------------------------------
// fpam_axis
// One output axis: two registered products, then a registered sum with the
// offset, shifted down and wrapped to the coordinate width.
// ----------------------------------------------------------------------------
module fpam_axis (
	input  logic                                  clk,
	input  fpam_pkg::pipe_ctl_t                   ctl,
	input  logic signed [fpam_pkg::COORD_W-1:0]   pos_a,
	input  logic signed [fpam_pkg::COORD_W-1:0]   coef_a,
	input  logic signed [fpam_pkg::COORD_W-1:0]   pos_b,
	input  logic signed [fpam_pkg::COORD_W-1:0]   coef_b,
	input  logic signed [fpam_pkg::COORD_W-1:0]   offset,
	output logic signed [fpam_pkg::COORD_W-1:0]   result_s3
);
	import fpam_pkg::*;

	localparam int PROD_HI = PROD_SHIFT + SUM_W - 1;

	logic signed [PROD_W-1:0] prod_a;
	logic signed [PROD_W-1:0] prod_b;
	logic        [SUM_W-1:0]  prod_a_s2;
	logic        [SUM_W-1:0]  prod_b_s2;
	logic        [SUM_W-1:0]  sum;

	assign prod_a = PROD_W'(pos_a) * PROD_W'(coef_a);
	assign prod_b = PROD_W'(pos_b) * PROD_W'(coef_b);

	// Only the low bits of the sum reach the wrapped result, so the
	// products are kept modulo the sum width.
	assign sum = prod_a_s2 + prod_b_s2 +
		{{(SUM_W-COORD_W){offset[COORD_W-1]}}, offset};

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			prod_a_s2 <= prod_a[PROD_HI:PROD_SHIFT];
			prod_b_s2 <= prod_b[PROD_HI:PROD_SHIFT];
		end
		if (ctl.load_s3) begin
			result_s3 <= sum[OUT_SHIFT+COORD_W-1:OUT_SHIFT];
		end
	end

endmodule

[hdl/fixed_point_polygon_affine_map_top.sv]
// ----------------------------------------------------------------------------
// fixed_point_polygon_affine_map_top
// Streams polygon vertices through a fixed-point 2D affine map and drops
// consecutive duplicate points within a polygon.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata: pos_x, pos_y; tuser: starts_polygon
// m_*       out  m_tvalid/m_tready  tdata: out_x, out_y; tuser: out_starts_polygon
// cfg_*     in   cfg_wr_en          cfg_index, cfg_data
//
// One item per cycle is accepted while no stage is stalled. An accepted item
// passes the input register, product register and sum register, then the
// duplicate check loads the output register. Each stage holds while the
// stage after it is full and stalled, and stages with bubbles keep filling.
// Reset clears the coefficients, the last emitted point and all valid flags.
// ----------------------------------------------------------------------------
module fixed_point_polygon_affine_map_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [2*fpam_pkg::COORD_W-1:0]     s_tdata,   // pos_x, pos_y
	input  logic [0:0]                         s_tuser,   // starts_polygon
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [2*fpam_pkg::COORD_W-1:0]     m_tdata,   // out_x, out_y
	output logic [0:0]                         m_tuser,   // out_starts_polygon
	input  logic                               cfg_wr_en,
	input  logic [fpam_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fpam_pkg::COORD_W-1:0]       cfg_data
);
	import fpam_pkg::*;

	logic signed [COORD_W-1:0] coef_xx_q, coef_yx_q, coef_xy_q, coef_yy_q;
	logic signed [COORD_W-1:0] offset_x_q, offset_y_q;

	logic                      v_s1, v_s2, v_s3;
	logic                      start_s1, start_s2, start_s3;
	logic signed [COORD_W-1:0] x_s1, y_s1;
	logic signed [COORD_W-1:0] ox_s3, oy_s3;
	logic        [COORD_W-1:0] prev_x_q, prev_y_q;

	logic                      out_valid_q;
	logic                      out_start_q;
	logic        [COORD_W-1:0] out_x_q, out_y_q;

	logic                      out_free;
	logic                      emit_s3;
	logic                      adv_s3;
	logic                      accept;
	pipe_ctl_t                 ctl;

	assign out_free    = !out_valid_q || m_tready;
	assign emit_s3     = start_s3 || (ox_s3 != prev_x_q) || (oy_s3 != prev_y_q);
	assign adv_s3      = v_s3 && (!emit_s3 || out_free);
	assign ctl.load_s3 = v_s2 && (!v_s3 || adv_s3);
	assign ctl.load_s2 = v_s1 && (!v_s2 || ctl.load_s3);
	assign s_tready    = !v_s1 || ctl.load_s2;
	assign accept      = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_xx_q  <= '0;
			coef_yx_q  <= '0;
			coef_xy_q  <= '0;
			coef_yy_q  <= '0;
			offset_x_q <= '0;
			offset_y_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_COEF_XX:  coef_xx_q  <= cfg_data;
				CFG_COEF_YX:  coef_yx_q  <= cfg_data;
				CFG_COEF_XY:  coef_xy_q  <= cfg_data;
				CFG_COEF_YY:  coef_yy_q  <= cfg_data;
				CFG_OFFSET_X: offset_x_q <= cfg_data;
				CFG_OFFSET_Y: offset_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
		end else begin
			v_s1 <= accept || (v_s1 && !ctl.load_s2);
			v_s2 <= ctl.load_s2 || (v_s2 && !ctl.load_s3);
			v_s3 <= ctl.load_s3 || (v_s3 && !adv_s3);
			if (adv_s3 && emit_s3) begin
				out_valid_q <= 1'b1;
				prev_x_q    <= ox_s3;
				prev_y_q    <= oy_s3;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1     <= s_tdata[COORD_W-1:0];
			y_s1     <= s_tdata[2*COORD_W-1:COORD_W];
			start_s1 <= s_tuser[0];
		end
		if (ctl.load_s2) begin
			start_s2 <= start_s1;
		end
		if (ctl.load_s3) begin
			start_s3 <= start_s2;
		end
		if (adv_s3 && emit_s3) begin
			out_x_q     <= ox_s3;
			out_y_q     <= oy_s3;
			out_start_q <= start_s3;
		end
	end

	fpam_axis u_axis_x (
		.clk       (clk),
		.ctl       (ctl),
		.pos_a     (x_s1),
		.coef_a    (coef_xx_q),
		.pos_b     (y_s1),
		.coef_b    (coef_yx_q),
		.offset    (offset_x_q),
		.result_s3 (ox_s3)
	);

	fpam_axis u_axis_y (
		.clk       (clk),
		.ctl       (ctl),
		.pos_a     (y_s1),
		.coef_a    (coef_yy_q),
		.pos_b     (x_s1),
		.coef_b    (coef_xy_q),
		.offset    (offset_y_q),
		.result_s3 (oy_s3)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_y_q, out_x_q};
	assign m_tuser  = out_start_q;

endmodule
